### hw/rtl/mbd_pkg.sv
// Shared types, constants and channel arithmetic for the mipmap box downsampler.
package mbd_pkg;

   // Pixel and channel geometry
   localparam int PIXEL_BITS    = 32;
   localparam int CHAN_BITS     = 8;
   localparam int CHAN_COUNT    = 4;
   localparam int CHAN_SUM_BITS = CHAN_BITS + 1;
   localparam int SUMS_BITS     = CHAN_SUM_BITS * CHAN_COUNT;
   localparam int BLOCK_BITS    = CHAN_SUM_BITS + 1;
   localparam int ALPHA_CHAN    = 3;

   // Alpha threshold and forced values
   localparam logic [CHAN_BITS-1:0] ALPHA_THRESHOLD = 8'd128;
   localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE    = 8'd255;
   localparam logic [CHAN_BITS-1:0] ALPHA_CLEAR     = 8'd0;

   // Configuration registers
   localparam int WIDTH_BITS     = 12;
   localparam int HEIGHT_BITS    = 13;
   localparam int ROW_BITS       = 12;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd2048;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd4096;
   localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT   = 13'd4096;
   localparam int DEF_MAX_WIDTH = 2048;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 1'd1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [SUMS_BITS-1:0]  sums_type;

   // A beat headed for the averaging stage
   typedef struct packed {
      logic     valid;
      logic     last;
      sums_type sums;
   } pipe_type;

   // Per-channel sums of two horizontally adjacent pixels, 9 bits per channel.
   function automatic sums_type pair_sums(input pixel_type a, input pixel_type b);
      sums_type packed_sums;
      packed_sums = '0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         packed_sums[c*CHAN_SUM_BITS +: CHAN_SUM_BITS] =
            CHAN_SUM_BITS'(a[c*CHAN_BITS +: CHAN_BITS]) +
            CHAN_SUM_BITS'(b[c*CHAN_BITS +: CHAN_BITS]);
      end
      return packed_sums;
   endfunction

   // Truncated mean of a 2x2 block from the upper and lower pair sums;
   // alpha is then forced fully opaque or fully clear.
   function automatic pixel_type block_mean(input sums_type upper, input sums_type lower);
      pixel_type              result;
      logic [BLOCK_BITS-1:0]  total;
      logic [CHAN_BITS-1:0]   mean;
      result = '0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         total = BLOCK_BITS'(upper[c*CHAN_SUM_BITS +: CHAN_SUM_BITS]) +
                 BLOCK_BITS'(lower[c*CHAN_SUM_BITS +: CHAN_SUM_BITS]);
         mean  = total[BLOCK_BITS-1:2];
         if (c == ALPHA_CHAN) begin
            mean = (mean >= ALPHA_THRESHOLD) ? ALPHA_OPAQUE : ALPHA_CLEAR;
         end
         result[c*CHAN_BITS +: CHAN_BITS] = mean;
      end
      return result;
   endfunction

endpackage

### hw/rtl/mipmap_box_downsample.sv
// Top level of the 2x2 box-filter mipmap downsampler.
//
// Source RGBA pixels enter in raster order on the req_ channel, one beat per
// pixel. Every aligned 2x2 block yields one beat on the rsp_ channel, in
// raster order of the half-size level; rsp_last_of_frame marks the final one.
// An odd last column or row produces no output.
// The csr_ port sets source_width (index 0) and source_height (index 1); any
// write restarts the frame at column 0, row 0. Write only while idle.
// Throughput is one source pixel per cycle while req_ready is high. The line
// store is a single-port memory: even rows write a pair sum on every odd
// column, odd rows read one, so it sees at most one access per cycle.
// rsp_valid follows the beat carrying the bottom-right pixel of its block:
// the line store read and the averaging stage are registered when that beat
// is accepted, and the block mean then passes into the output register.
// When the receiver stalls, one result waits in the output register and one
// more in the averaging stage; input beats keep flowing until both are full.
// Reset clears the counters and valid flags and restores the full-size
// defaults of 2048 by 4096; the line store is not cleared.
module mipmap_box_downsample #(
   parameter int MAX_WIDTH = mbd_pkg::DEF_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbd_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mbd_pkg::PIXEL_BITS-1:0]       req_pixel_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mbd_pkg::PIXEL_BITS-1:0]       rsp_pixel_out,
   output logic                                 rsp_last_of_frame
);

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int AW         = $clog2(LINE_DEPTH);

   logic              line_en, line_we, take;
   logic [AW-1:0]     line_addr;
   mbd_pkg::sums_type line_wdata, line_rdata;
   mbd_pkg::pipe_type pipe;

   assign req_ready = take;

   // Position tracking and pair sums
   mbd_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (take),
      .req_pixel_in     (req_pixel_in),
      .line_en          (line_en),
      .line_we          (line_we),
      .line_addr        (line_addr),
      .line_wdata       (line_wdata),
      .pipe             (pipe)
   );

   // Pair sums of the even row
   mbd_line_store #(
      .DEPTH (LINE_DEPTH),
      .AW    (AW)
   ) u_line_store (
      .clock (clock),
      .en    (line_en),
      .we    (line_we),
      .addr  (line_addr),
      .wdata (line_wdata),
      .rdata (line_rdata)
   );

   // Block mean and output register
   mbd_reduce u_reduce (
      .clock             (clock),
      .reset             (reset),
      .pipe              (pipe),
      .line_rdata        (line_rdata),
      .rsp_ready         (rsp_ready),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

### hw/rtl/mbd_line_store.sv
// Single-port line store holding the pair sums of one even source row.
module mbd_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                en,
   input  logic                we,
   input  logic [AW-1:0]       addr,
   input  mbd_pkg::sums_type   wdata,
   output mbd_pkg::sums_type   rdata
);

   mbd_pkg::sums_type mem [DEPTH];
   mbd_pkg::sums_type rdata_ff;

   // One access per cycle: a write, or a read whose data is registered and held.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/mbd_scan.sv
// Raster position tracking, configuration registers and line store requests.
module mbd_scan #(
   parameter int MAX_WIDTH = mbd_pkg::DEF_MAX_WIDTH,
   parameter int AW        = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbd_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  mbd_pkg::pixel_type                   req_pixel_in,
   output logic                                 line_en,
   output logic                                 line_we,
   output logic [AW-1:0]                        line_addr,
   output mbd_pkg::sums_type                    line_wdata,
   output mbd_pkg::pipe_type                    pipe
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int MWB = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (MWB > mbd_pkg::WIDTH_BITS) ? MWB : mbd_pkg::WIDTH_BITS;
   localparam int HW  = mbd_pkg::HEIGHT_BITS;
   localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

   logic [mbd_pkg::WIDTH_BITS-1:0] width_ff;
   logic [HW-1:0]                  height_ff;
   logic [CW-1:0]                  col_ff;
   logic [mbd_pkg::ROW_BITS-1:0]   row_ff;
   mbd_pkg::pixel_type             left_ff;

   logic [EW-1:0] width_eff, width_even, col_wide;
   logic [HW-1:0] height_eff, height_even, row_wide;
   logic          col_wrap, row_wrap, last_col, last_row, accept;

   // Effective frame size: saturate, then round down to even for the final block.
   always_comb begin
      width_eff   = (EW'(width_ff) > MAX_W) ? MAX_W : EW'(width_ff);
      height_eff  = (height_ff > mbd_pkg::MAX_HEIGHT) ? mbd_pkg::MAX_HEIGHT : height_ff;
      width_even  = {width_eff[EW-1:1], 1'b0};
      height_even = {height_eff[HW-1:1], 1'b0};
      col_wide    = EW'(col_ff) + EW'(1);
      row_wide    = HW'(row_ff) + HW'(1);
      col_wrap    = col_wide >= width_eff;
      row_wrap    = row_wide >= height_eff;
      last_col    = (width_even != '0) && (EW'(col_ff) == width_even - EW'(1));
      last_row    = (height_even != '0) && (HW'(row_ff) == height_even - HW'(1));
   end

   assign accept = req_valid && req_ready;

   // Odd columns complete a pair: even rows store it, odd rows read the row above.
   always_comb begin
      line_wdata = mbd_pkg::pair_sums(left_ff, req_pixel_in);
      line_en    = accept && col_ff[0];
      line_we    = !row_ff[0];
      line_addr  = AW'(col_ff >> 1);
      pipe.valid = accept && col_ff[0] && row_ff[0];
      pipe.last  = last_col && last_row;
      pipe.sums  = line_wdata;
   end

   // Configuration registers and raster counters; a register write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbd_pkg::WIDTH_RESET;
         height_ff <= mbd_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mbd_pkg::REG_SOURCE_WIDTH: begin
               width_ff <= csr_write_data[mbd_pkg::WIDTH_BITS-1:0];
            end
            mbd_pkg::REG_SOURCE_HEIGHT: begin
               height_ff <= csr_write_data[HW-1:0];
            end
            default: begin
            end
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? '0 : row_wide[mbd_pkg::ROW_BITS-1:0];
         end else begin
            col_ff <= col_wide[CW-1:0];
         end
      end
   end

   // The even-column pixel waits here for its right neighbor.
   always_ff @(posedge clock) begin
      if (accept && !col_ff[0]) begin
         left_ff <= req_pixel_in;
      end
   end

endmodule

### hw/rtl/mbd_reduce.sv
// Averaging stage and output register for the reduced pixels.
module mbd_reduce (
   input  logic                clock,
   input  logic                reset,
   input  mbd_pkg::pipe_type   pipe,
   input  mbd_pkg::sums_type   line_rdata,
   input  logic                rsp_ready,
   output logic                take,
   output logic                rsp_valid,
   output mbd_pkg::pixel_type  rsp_pixel_out,
   output logic                rsp_last_of_frame
);

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_last_ff;
   mbd_pkg::sums_type  s1_sums_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   mbd_pkg::pixel_type rsp_pixel_ff;
   logic               rsp_last_ff;
   logic               out_free, advance;

   // The stage moves on whenever the output register is empty or being drained.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      advance      = s1_valid_ff && out_free;
      take         = !s1_valid_ff || out_free;
      s1_valid_in  = take ? pipe.valid : s1_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Lower pair sums are registered alongside the line store read data.
   always_ff @(posedge clock) begin
      if (take && pipe.valid) begin
         s1_sums_ff <= pipe.sums;
         s1_last_ff <= pipe.last;
      end
   end

   // Block mean into the output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= mbd_pkg::block_mean(line_rdata, s1_sums_ff);
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule
